[rtl/cidf_pkg.sv]
// Package for the caller-ID FSK deframer: phase encoding, framing byte codes
// and the event record passed from the step logic to the top level.
// Depends on nothing.
package cidf_pkg;

  localparam logic [7:0] SeizeByte  = 8'h55;
  localparam logic [7:0] TypeA      = 8'h02;
  localparam logic [7:0] TypeB      = 8'h04;
  localparam logic [7:0] ShortLimit = 8'h10;
  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] IndexMax   = 8'hFF;

  typedef enum logic [1:0] {
    PhWait   = 2'd0,
    PhSeized = 2'd1,
    PhTyped  = 2'd2,
    PhDigits = 2'd3
  } phase_e;

  typedef enum logic {
    EvDigit  = 1'b0,
    EvFinish = 1'b1
  } event_e;

  typedef struct packed {
    logic       valid;
    event_e     kind;
    logic [7:0] value;
    logic [7:0] index;
  } event_t;

endpackage

[rtl/caller_id_fsk_deframer.sv]
// Top level of the caller-ID FSK deframer: input register, framing logic
// and output register on stream interfaces.
// Depends on cidf_pkg and cidf_core.
// An event passes through the input register and then the output register on its way to the master side.
// Throughput: one byte per cycle, limited only by master-side back-pressure.
// The input and output registers each hold one request; slave-side ready follows master-side ready.
// Reset clears the phase, the seizure run, the counts and both valid flags.
module caller_id_fsk_deframer #(
  parameter int BUF_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] digit_value, [15:8] digit_index
  output logic        m_axis_tuser    // [0] event_kind
);

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             out_valid_q;
  logic             out_kind_q;
  logic [15:0]      out_data_q;
  logic             advance;
  logic             out_free;
  cidf_pkg::event_t event_w;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  cidf_core #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .event_o(event_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && event_w.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && event_w.valid) begin
      out_kind_q <= event_w.kind;
      out_data_q <= {event_w.index, event_w.value};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == cidf_pkg::EvFinish |-> m_axis_tdata[7:0] == 8'h00)
    else $error("Finish event carries a non-zero digit value.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> in_valid_q && out_free)
    else $error("Framing logic stepped without a held byte or a free output.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !out_free |=> in_valid_q && $stable(in_byte_q))
    else $error("Held byte was lost while the output was stalled.");

endmodule

[rtl/cidf_core.sv]
// Framing state machine of the caller-ID FSK deframer: seizure, type, length
// and digit phases, one received byte per enabled cycle.
// Depends on cidf_pkg.
module cidf_core #(
  parameter int BUF_DEPTH = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  output cidf_pkg::event_t event_o
);

  localparam int CntW = $clog2(BUF_DEPTH + 1);

  cidf_pkg::phase_e phase_q, phase_d;
  logic [1:0]       run_q, run_d;
  logic [CntW-1:0]  expected_q, expected_d;
  logic [CntW-1:0]  stored_q, stored_d;
  logic [8:0]       stored_ext;

  assign stored_ext = 9'(stored_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= cidf_pkg::PhWait;
      run_q      <= '0;
      expected_q <= '0;
      stored_q   <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      run_q      <= run_d;
      expected_q <= expected_d;
      stored_q   <= stored_d;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    run_d      = run_q;
    expected_d = expected_q;
    stored_d   = stored_q;
    event_o    = '{valid: 1'b0, kind: cidf_pkg::EvDigit, value: 8'h00, index: 8'h00};
    unique case (phase_q)
      cidf_pkg::PhWait: begin
        if (byte_i == cidf_pkg::SeizeByte) begin
          if (run_q == 2'd2) begin
            run_d   = '0;
            phase_d = cidf_pkg::PhSeized;
          end else begin
            run_d = run_q + 2'd1;
          end
        end else begin
          run_d = '0;
        end
      end
      cidf_pkg::PhSeized: begin
        if (byte_i == cidf_pkg::TypeA || byte_i == cidf_pkg::TypeB) begin
          phase_d = cidf_pkg::PhTyped;
        end
      end
      cidf_pkg::PhTyped: begin
        if (byte_i < cidf_pkg::ShortLimit) begin
          expected_d = CntW'(byte_i[3:0]);
        end else begin
          expected_d = CntW'(BUF_DEPTH);
        end
        stored_d = '0;
        phase_d  = cidf_pkg::PhDigits;
      end
      cidf_pkg::PhDigits: begin
        event_o.valid = 1'b1;
        if (stored_q < expected_q) begin
          event_o.kind  = cidf_pkg::EvDigit;
          event_o.value = byte_i - cidf_pkg::AsciiZero;
          event_o.index = stored_ext[7:0];
          stored_d      = stored_q + CntW'(1);
        end else begin
          event_o.kind  = cidf_pkg::EvFinish;
          event_o.index = stored_ext[8] ? cidf_pkg::IndexMax : stored_ext[7:0];
          phase_d       = cidf_pkg::PhWait;
        end
      end
      default: begin
        phase_d = cidf_pkg::PhWait;
      end
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == cidf_pkg::PhDigits |-> stored_q <= expected_q)
    else $error("Digit count has passed the message length.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q != 2'd3)
    else $error("Seizure run has reached an impossible value.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_o.valid |-> phase_q == cidf_pkg::PhDigits)
    else $error("An event was raised outside the digit phase.");

endmodule

[sim/caller_id_fsk_deframer_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for caller_id_fsk_deframer: directed and random caller-ID
// byte streams with random idling on both stream sides, checked against a local predictor.
// Depends on cidf_pkg and the RTL of caller_id_fsk_deframer.
module caller_id_fsk_deframer_test;

  localparam int Depth = 256;

  typedef struct packed {
    cidf_pkg::event_e kind;
    logic [7:0]       value;
    logic [7:0]       index;
  } cid_event_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       drain;
  } fsk_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;

  fsk_byte_t  byte_queue[$];
  cid_event_t event_queue[$];
  int         mismatches = 0;
  int         items_queued = 0;
  int         send_gap = 0;
  int         stall_left = 0;
  bit         send_calm = 1'b0;
  bit         recv_calm = 1'b0;

  cidf_pkg::phase_e frame_phase = cidf_pkg::PhWait;
  logic [1:0]       seize_count = 2'd0;
  logic [8:0]       digits_due = 9'd0;
  logic [8:0]       digits_done = 9'd0;

  caller_id_fsk_deframer #(
    .BUF_DEPTH(Depth)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void deframe_byte(input logic [7:0] rx);
    cid_event_t ev;
    case (frame_phase)
      cidf_pkg::PhWait: begin
        if (rx == cidf_pkg::SeizeByte) begin
          if (seize_count == 2'd2) begin
            seize_count = 2'd0;
            frame_phase = cidf_pkg::PhSeized;
          end else begin
            seize_count = seize_count + 2'd1;
          end
        end else begin
          seize_count = 2'd0;
        end
      end
      cidf_pkg::PhSeized: begin
        if (rx == cidf_pkg::TypeA || rx == cidf_pkg::TypeB) frame_phase = cidf_pkg::PhTyped;
      end
      cidf_pkg::PhTyped: begin
        digits_due  = (rx < cidf_pkg::ShortLimit) ? {1'b0, rx} : 9'(Depth);
        digits_done = 9'd0;
        frame_phase = cidf_pkg::PhDigits;
      end
      default: begin
        if (digits_done < digits_due) begin
          ev.kind     = cidf_pkg::EvDigit;
          ev.value    = rx - cidf_pkg::AsciiZero;
          ev.index    = digits_done[7:0];
          digits_done = digits_done + 9'd1;
        end else begin
          ev.kind     = cidf_pkg::EvFinish;
          ev.value    = 8'h00;
          ev.index    = (digits_done > 9'd255) ? cidf_pkg::IndexMax : digits_done[7:0];
          frame_phase = cidf_pkg::PhWait;
        end
        event_queue.push_back(ev);
      end
    endcase
  endfunction

  function automatic int pick_idle(inout bit calm);
    if ($urandom_range(0, 63) == 0) calm = !calm;
    if (calm) return 0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 0;
      5, 6, 7, 8:    return $urandom_range(1, 3);
      default:       return $urandom_range(8, 40);
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] rx, input bit drain);
    byte_queue.push_back(fsk_byte_t'{rx, drain});
    items_queued++;
  endtask

  task automatic push_message(input logic [7:0] kind_byte, input logic [7:0] len,
                              input bit drain, input bit junk);
    int         count;
    logic [7:0] stray;
    count = (len < cidf_pkg::ShortLimit) ? int'(len) : Depth;
    push_byte(cidf_pkg::SeizeByte, drain);
    push_byte(cidf_pkg::SeizeByte, 1'b0);
    push_byte(cidf_pkg::SeizeByte, 1'b0);
    if (junk) begin
      repeat ($urandom_range(1, 3)) begin
        stray = 8'($urandom);
        if (stray == cidf_pkg::TypeA || stray == cidf_pkg::TypeB) stray = 8'h03;
        push_byte(stray, 1'b0);
      end
    end
    push_byte(kind_byte, 1'b0);
    push_byte(len, 1'b0);
    repeat (count) push_byte(8'($urandom), 1'b0);
    push_byte(8'($urandom), 1'b0);
  endtask

  // Sender: a request is presented when the gap counter has run out, a byte is queued and no event blocks a drain byte.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) deframe_byte(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap      <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (byte_queue.size() != 0 &&
                     !(byte_queue[0].drain && event_queue.size() != 0)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= byte_queue[0].rx_byte;
          void'(byte_queue.pop_front());
          send_gap      <= pick_idle(send_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compares each result request with the oldest prediction.
  always @(posedge clk_i) begin
    cid_event_t seen;
    cid_event_t want;
    int         stall;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.kind  = cidf_pkg::event_e'(m_axis_tuser);
        seen.value = m_axis_tdata[7:0];
        seen.index = m_axis_tdata[15:8];
        if (event_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected event: kind %0d value %02h index %0d",
                     seen.kind, seen.value, seen.index);
        end else begin
          want = event_queue.pop_front();
          if (seen.kind !== want.kind || seen.value !== want.value ||
              seen.index !== want.index) begin
            mismatches++;
            if (mismatches <= 10)
              $display("event mismatch: kind %0d/%0d value %02h/%02h index %0d/%0d",
                       want.kind, seen.kind, want.value, seen.value,
                       want.index, seen.index);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left    <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if (m_axis_tvalid && m_axis_tready) begin
        stall = pick_idle(recv_calm);
        m_axis_tready <= (stall == 0);
        stall_left    <= (stall > 0) ? stall - 1 : 0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    int         msg;
    int         pick;
    logic [7:0] len;
    // Broken seizure, then a full one; stray type bytes; zero length.
    push_byte(cidf_pkg::SeizeByte, 1'b0);
    push_byte(cidf_pkg::SeizeByte, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(cidf_pkg::SeizeByte, 1'b0);
    push_byte(cidf_pkg::SeizeByte, 1'b0);
    push_byte(cidf_pkg::SeizeByte, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(cidf_pkg::TypeA, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hAA, 1'b0);
    // Short message with extreme digit bytes.
    push_byte(cidf_pkg::SeizeByte, 1'b0);
    push_byte(cidf_pkg::SeizeByte, 1'b0);
    push_byte(cidf_pkg::SeizeByte, 1'b0);
    push_byte(cidf_pkg::TypeB, 1'b0);
    push_byte(8'h03, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(cidf_pkg::AsciiZero, 1'b0);
    push_byte(8'h7E, 1'b0);

    msg = 0;
    while (items_queued < 800) begin
      pick = $urandom_range(0, 99);
      if (pick < 15 && msg > 2) begin
        repeat ($urandom_range(1, 8))
          push_byte($urandom_range(0, 1) ? cidf_pkg::SeizeByte : 8'($urandom), 1'b0);
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          push_byte(cidf_pkg::SeizeByte, 1'b0);
          push_byte(cidf_pkg::SeizeByte, 1'b0);
          push_byte(8'($urandom_range(0, 84)), 1'b0);
        end
        if (msg == 2)
          len = 8'hFF;
        else if (msg == 5)
          len = cidf_pkg::ShortLimit;
        else if (items_queued < 500 && $urandom_range(0, 29) == 0)
          len = 8'($urandom_range(16, 255));
        else
          len = 8'($urandom_range(0, 15));
        push_message($urandom_range(0, 1) ? cidf_pkg::TypeA : cidf_pkg::TypeB, len,
                     msg == 1 || $urandom_range(0, 19) == 0,
                     $urandom_range(0, 4) == 0);
        msg++;
      end
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_queue.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (event_queue.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && event_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
